/* sv/crc_byte_stuffing_frame_encoder_macros.svh */
// assertion macros for the checker file
`ifndef CRC_BYTE_STUFFING_FRAME_ENCODER_MACROS_SVH
`define CRC_BYTE_STUFFING_FRAME_ENCODER_MACROS_SVH

// antecedent holds, consequent holds in the same cycle
`define CRCBS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("crcbs check failed");

// antecedent holds, consequent holds in the next cycle
`define CRCBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("crcbs check failed");

`endif

/* sv/crcbs_pkg.sv */
package crcbs_pkg;

	localparam int BYTE_W      = 8;
	localparam int PADDR_W     = 4;
	localparam int PDATA_W     = 32;
	localparam int QUEUE_DEPTH = 4;

	// register reset values
	localparam logic [BYTE_W-1:0] FLAG_RESET   = 8'h7E;
	localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'h1B;
	localparam logic [BYTE_W-1:0] POLY_RESET   = 8'h07;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_FLAG   = 2'd0;
	localparam logic [1:0] REG_ESCAPE = 2'd1;
	localparam logic [1:0] REG_POLY   = 2'd2;

	// bit positions of the pending-step mask in the back end
	localparam int STEP_OPEN  = 0;
	localparam int STEP_ESC_D = 1;
	localparam int STEP_DATA  = 2;
	localparam int STEP_ESC_C = 3;
	localparam int STEP_CRC   = 4;
	localparam int STEP_CLOSE = 5;
	localparam int STEPS      = 6;

	typedef struct packed {
		logic [BYTE_W-1:0] flag;
		logic [BYTE_W-1:0] escape;
		logic [BYTE_W-1:0] poly;
	} cfg_t;

	// one classified word waiting for the back end
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic [BYTE_W-1:0] crc;
		logic              open;
		logic              last;
		logic              esc_data;
		logic              esc_crc;
	} entry_t;

	// queue status seen by the back end
	typedef struct packed {
		logic   avail;
		entry_t head;
	} queue_rd_t;

	// crc-8, reflected, one byte
	function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
		input logic [BYTE_W-1:0] b, input logic [BYTE_W-1:0] poly);
		logic [BYTE_W-1:0] c;
		c = crc ^ b;
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[0]) begin
				c = c ^ poly;
			end
			c = c >> 1;
		end
		return c;
	endfunction

endpackage

/* sv/crc_byte_stuffing_frame_encoder.sv */
// channel   dir  handshake                 payload
// item      in   item_valid / item_ready   data_byte, last_of_frame
// byte      out  byte_valid / byte_ready   out_byte, last_of_run
// config    in   apb psel/penable/pwrite   paddr, pwdata, prdata
//
// one stuffed byte leaves per cycle while byte_ready is high; a word yields
// 1 to 6 bytes, usually 1 or 2, which the back-end sequencer sends in turn.
// the front takes a word every cycle while the queue has room.
// a word goes to a queue slot, then cur_q and mask_q, then the output register.
// asynchronous active-low reset clears frame state, queue and output register.
// either side may stall on its own; the queue and output register absorb it.
module crc_byte_stuffing_frame_encoder #(
	parameter int QUEUE_DEPTH = crcbs_pkg::QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic [7:0]                    data_byte,
	input  logic                          last_of_frame,
	output logic                          byte_valid,
	input  logic                          byte_ready,
	output logic [7:0]                    out_byte,
	output logic                          last_of_run,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [crcbs_pkg::PADDR_W-1:0] paddr,
	input  logic [crcbs_pkg::PDATA_W-1:0] pwdata,
	output logic [crcbs_pkg::PDATA_W-1:0] prdata,
	output logic                          pready
);
	import crcbs_pkg::*;

	cfg_t      cfg_q;
	logic      cfg_wr;
	logic      push;
	logic      pop;
	logic      queue_full;
	entry_t    wr_entry;
	queue_rd_t rd;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flag   <= FLAG_RESET;
			cfg_q.escape <= ESCAPE_RESET;
			cfg_q.poly   <= POLY_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_FLAG:   cfg_q.flag   <= pwdata[BYTE_W-1:0];
				REG_ESCAPE: cfg_q.escape <= pwdata[BYTE_W-1:0];
				REG_POLY:   cfg_q.poly   <= pwdata[BYTE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// register readback
	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			REG_FLAG:   prdata[BYTE_W-1:0] = cfg_q.flag;
			REG_ESCAPE: prdata[BYTE_W-1:0] = cfg_q.escape;
			REG_POLY:   prdata[BYTE_W-1:0] = cfg_q.poly;
			default:    prdata = '0;
		endcase
	end

	crcbs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.data_byte     (data_byte),
		.last_of_frame (last_of_frame),
		.cfg           (cfg_q),
		.queue_full    (queue_full),
		.push          (push),
		.entry         (wr_entry)
	);

	crcbs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.full     (queue_full),
		.pop      (pop),
		.rd       (rd)
	);

	crcbs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.rd          (rd),
		.pop         (pop),
		.byte_valid  (byte_valid),
		.byte_ready  (byte_ready),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

endmodule

/* sv/crcbs_front.sv */
module crcbs_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_ready,
	input  logic [7:0]              data_byte,
	input  logic                    last_of_frame,
	input  crcbs_pkg::cfg_t         cfg,
	input  logic                    queue_full,
	output logic                    push,
	output crcbs_pkg::entry_t       entry
);
	import crcbs_pkg::*;

	logic              in_frame_q;
	logic [BYTE_W-1:0] crc_q;
	logic [BYTE_W-1:0] crc_base;
	logic [BYTE_W-1:0] crc_next;

	assign item_ready = !queue_full;
	assign push       = item_valid && item_ready;

	// running crc, restarted when a frame opens
	assign crc_base = in_frame_q ? crc_q : '0;
	assign crc_next = crc8_update(crc_base, data_byte, cfg.poly);

	// classify the word for the back end
	always_comb begin
		entry.data     = data_byte;
		entry.crc      = crc_next;
		entry.open     = !in_frame_q;
		entry.last     = last_of_frame;
		entry.esc_data = (data_byte == cfg.flag) || (data_byte == cfg.escape);
		entry.esc_crc  = (crc_next == cfg.flag) || (crc_next == cfg.escape);
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			crc_q      <= '0;
		end else if (push) begin
			in_frame_q <= !last_of_frame;
			crc_q      <= last_of_frame ? '0 : crc_next;
		end
	end

endmodule

/* sv/crcbs_queue.sv */
module crcbs_queue #(
	parameter int DEPTH = crcbs_pkg::QUEUE_DEPTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  crcbs_pkg::entry_t       wr_entry,
	output logic                    full,
	input  logic                    pop,
	output crcbs_pkg::queue_rd_t    rd
);
	import crcbs_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t           slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign rd.avail = (count_q != '0);
	assign rd.head  = slots_q[rd_ptr_q];
	assign do_pop   = pop && rd.avail;

	// payload slots
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wr_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* sv/crcbs_back.sv */
module crcbs_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  crcbs_pkg::cfg_t         cfg,
	input  crcbs_pkg::queue_rd_t    rd,
	output logic                    pop,
	output logic                    byte_valid,
	input  logic                    byte_ready,
	output logic [7:0]              out_byte,
	output logic                    last_of_run
);
	import crcbs_pkg::*;

	entry_t            cur_q;
	logic [STEPS-1:0]  mask_q;
	logic [STEPS-1:0]  low;
	logic [STEPS-1:0]  mask_after;
	logic [STEPS-1:0]  new_mask;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;
	logic              slot_free;
	logic              advance;
	logic [BYTE_W-1:0] step_byte;

	// lowest pending step goes out next
	assign low        = mask_q & (~mask_q + 1'b1);
	assign mask_after = mask_q & ~low;
	assign slot_free  = !out_valid_q || byte_ready;
	assign advance    = (mask_q != '0) && slot_free;
	assign pop        = rd.avail && ((mask_q == '0) || (advance && (mask_after == '0)));

	// steps needed for the entry at the queue head
	always_comb begin
		new_mask             = '0;
		new_mask[STEP_OPEN]  = rd.head.open;
		new_mask[STEP_ESC_D] = rd.head.esc_data;
		new_mask[STEP_DATA]  = 1'b1;
		new_mask[STEP_ESC_C] = rd.head.last && rd.head.esc_crc;
		new_mask[STEP_CRC]   = rd.head.last;
		new_mask[STEP_CLOSE] = rd.head.last;
	end

	// byte for the current step
	always_comb begin
		priority if (low[STEP_OPEN]) begin
			step_byte = cfg.flag;
		end else if (low[STEP_ESC_D]) begin
			step_byte = cfg.escape;
		end else if (low[STEP_DATA]) begin
			step_byte = cur_q.data;
		end else if (low[STEP_ESC_C]) begin
			step_byte = cfg.escape;
		end else if (low[STEP_CRC]) begin
			step_byte = cur_q.crc;
		end else begin
			step_byte = cfg.flag;
		end
	end

	// current entry payload
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= rd.head;
		end
	end

	// step sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (pop) begin
			mask_q <= new_mask;
		end else if (advance) begin
			mask_q <= mask_after;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (byte_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q <= step_byte;
			out_last_q <= (mask_after == '0);
		end
	end

	assign byte_valid  = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = out_last_q;

endmodule

/* sv/crcbs_checker.sv */
`include "crc_byte_stuffing_frame_encoder_macros.svh"

module crcbs_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	input  logic                          item_ready,
	input  logic [7:0]                    data_byte,
	input  logic                          last_of_frame,
	input  logic                          byte_valid,
	input  logic                          byte_ready,
	input  logic [7:0]                    out_byte,
	input  logic                          last_of_run,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [crcbs_pkg::PADDR_W-1:0] paddr,
	input  logic [crcbs_pkg::PDATA_W-1:0] pwdata,
	input  logic [crcbs_pkg::PDATA_W-1:0] prdata,
	input  logic                          pready
);
	import crcbs_pkg::*;

	// a waiting input word holds
	`CRCBS_ASSERT_NEXT(a_in_hold, clk, arst_n, item_valid && !item_ready,
		item_valid && $stable(data_byte) && $stable(last_of_frame))

	// a stalled output word holds
	`CRCBS_ASSERT_NEXT(a_out_hold, clk, arst_n, byte_valid && !byte_ready,
		byte_valid && $stable(out_byte) && $stable(last_of_run))

	// no wait states on the register port
	`CRCBS_ASSERT_SAME(a_pready_high, clk, arst_n, 1'b1, pready)

	// registers are eight bits wide, upper readback bits stay zero
	`CRCBS_ASSERT_SAME(a_prdata_upper, clk, arst_n, 1'b1, prdata[PDATA_W-1:BYTE_W] == '0)

	// a flag write reads back on the next cycle
	`CRCBS_ASSERT_NEXT(a_flag_readback, clk, arst_n,
		psel && penable && pwrite && (paddr[3:2] == REG_FLAG),
		(paddr[3:2] != REG_FLAG) || (prdata[BYTE_W-1:0] == $past(pwdata[BYTE_W-1:0])))

endmodule

bind crc_byte_stuffing_frame_encoder crcbs_checker u_crcbs_checker (.*);

/* verif/tb_crc_byte_stuffing_frame_encoder.sv */
module tb_crc_byte_stuffing_frame_encoder;
	timeunit 1ns;
	timeprecision 1ps;

	import crcbs_pkg::*;

	// register index that decodes to nothing
	localparam logic [1:0] REG_NONE = 2'd3;
	localparam int QUIET_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 16;
	localparam int PRINT_CAP    = 40;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} word_t;

	typedef struct packed {
		logic [7:0] value;
		logic       fin;
	} line_byte_t;

	logic               clk           = 1'b0;
	logic               arst_n        = 1'b0;
	logic               item_valid    = 1'b0;
	logic               item_ready;
	logic [7:0]         data_byte     = 8'h00;
	logic               last_of_frame = 1'b0;
	logic               byte_valid;
	logic               byte_ready    = 1'b0;
	logic [7:0]         out_byte;
	logic               last_of_run;
	logic               psel          = 1'b0;
	logic               penable       = 1'b0;
	logic               pwrite        = 1'b0;
	logic [PADDR_W-1:0] paddr         = '0;
	logic [PDATA_W-1:0] pwdata        = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	crc_byte_stuffing_frame_encoder u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.data_byte     (data_byte),
		.last_of_frame (last_of_frame),
		.byte_valid    (byte_valid),
		.byte_ready    (byte_ready),
		.out_byte      (out_byte),
		.last_of_run   (last_of_run),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// words waiting to be sent, line bytes still to arrive
	word_t      word_q[$];
	line_byte_t line_q[$];

	// encoder shadow: registers and frame state
	cfg_t       enc_cfg = '{flag: FLAG_RESET, escape: ESCAPE_RESET, poly: POLY_RESET};
	logic       frame_open = 1'b0;
	logic [7:0] frame_crc  = 8'h00;

	int   mismatches   = 0;
	int   quiet_cycles = 0;
	logic word_taken   = 1'b0;
	int   word_gap     = 0;
	int   send_calm    = 0;
	int   hold_gap     = 0;
	int   recv_calm    = 0;

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= PRINT_CAP) begin
			$display("mismatch at %0t ns: %s", $time, msg);
		end
	endtask

	// reflected crc-8 over one byte
	function automatic logic [7:0] crc_fold(input logic [7:0] acc, input logic [7:0] b,
		input logic [7:0] poly);
		logic [7:0] c;
		c = acc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = c ^ poly;
			end
			c = c >> 1;
		end
		return c;
	endfunction

	// escape a byte that collides with flag or escape
	function automatic void push_stuffed(ref line_byte_t run[$], input logic [7:0] b);
		if (b == enc_cfg.flag || b == enc_cfg.escape) begin
			run.push_back('{value: enc_cfg.escape, fin: 1'b0});
		end
		run.push_back('{value: b, fin: 1'b0});
	endfunction

	// line bytes caused by one payload word
	task automatic encode_word(input word_t w);
		line_byte_t run[$];
		if (!frame_open) begin
			run.push_back('{value: enc_cfg.flag, fin: 1'b0});
			frame_open = 1'b1;
			frame_crc  = 8'h00;
		end
		push_stuffed(run, w.data);
		frame_crc = crc_fold(frame_crc, w.data, enc_cfg.poly);
		if (w.last) begin
			push_stuffed(run, frame_crc);
			run.push_back('{value: enc_cfg.flag, fin: 1'b0});
			frame_open = 1'b0;
			frame_crc  = 8'h00;
		end
		run[run.size()-1].fin = 1'b1;
		foreach (run[i]) begin
			line_q.push_back(run[i]);
		end
	endtask

	// pause length: mostly none or short, a few long, with calm stretches
	function automatic int pick_pause(ref int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// monitor: accept words into the predictor, check line bytes
	always @(posedge clk) begin : monitor
		line_byte_t want;
		logic       moved;
		logic       taken;
		moved = 1'b0;
		taken = 1'b0;
		if (arst_n) begin
			if (item_valid && item_ready) begin
				encode_word('{data: data_byte, last: last_of_frame});
				taken = 1'b1;
				moved = 1'b1;
			end
			if (byte_valid && byte_ready) begin
				moved = 1'b1;
				if (line_q.size() == 0) begin
					report_mismatch($sformatf("unexpected byte %02h last %0b",
						out_byte, last_of_run));
				end else begin
					want = line_q.pop_front();
					if (out_byte !== want.value) begin
						report_mismatch($sformatf("out_byte %02h, wanted %02h",
							out_byte, want.value));
					end
					if (last_of_run !== want.fin) begin
						report_mismatch($sformatf("last_of_run %0b, wanted %0b (byte %02h)",
							last_of_run, want.fin, want.value));
					end
				end
			end
		end
		word_taken <= taken;
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
	end

	// word driver
	always @(negedge clk) begin : driver
		word_t nxt;
		if (!(item_valid && !word_taken)) begin
			if (word_gap > 0) begin
				item_valid <= 1'b0;
				word_gap--;
			end else if (word_q.size() != 0) begin
				nxt = word_q.pop_front();
				item_valid    <= 1'b1;
				data_byte     <= nxt.data;
				last_of_frame <= nxt.last;
				word_gap = pick_pause(send_calm);
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// line side back-pressure
	always @(negedge clk) begin : receiver
		if (hold_gap > 0) begin
			byte_ready <= 1'b0;
			hold_gap--;
		end else begin
			byte_ready <= 1'b1;
			hold_gap = pick_pause(recv_calm);
		end
	end

	// runs out when nothing moves for too long
	initial begin : watchdog
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("FAIL");
		$finish;
	end

	// apb transfers start and end at a falling edge
	task automatic apb_write(input logic [1:0] idx, input logic [7:0] v);
		logic [31:0] rnd;
		rnd = $urandom();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= {rnd[31:8], v};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
	endtask

	task automatic apb_read_check(input logic [1:0] idx, input logic [7:0] v, input string nm);
		logic [7:0] got;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= PADDR_W'({idx, 2'b00});
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		got = prdata[7:0];
		@(negedge clk);
		if (got !== v) begin
			report_mismatch($sformatf("%s reads %02h, wanted %02h", nm, got, v));
		end
	endtask

	task automatic apb_release();
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic check_regs();
		apb_read_check(REG_FLAG, enc_cfg.flag, "flag_value");
		apb_read_check(REG_ESCAPE, enc_cfg.escape, "escape_value");
		apb_read_check(REG_POLY, enc_cfg.poly, "crc_poly");
		apb_release();
	endtask

	// block is idle once every word is in and every byte is out
	task automatic wait_drained();
		while (word_q.size() != 0 || item_valid || line_q.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic set_config(input cfg_t c);
		wait_drained();
		apb_write(REG_FLAG, c.flag);
		apb_write(REG_ESCAPE, c.escape);
		apb_write(REG_POLY, c.poly);
		enc_cfg = c;
		check_regs();
	endtask

	task automatic queue_word(input logic [7:0] d, input logic last);
		word_q.push_back('{data: d, last: last});
	endtask

	// single-byte frame whose crc lands on the given byte, if one exists
	task automatic queue_crc_hit(input logic [7:0] target);
		for (int b = 0; b < 256; b++) begin
			if (crc_fold(8'h00, b[7:0], enc_cfg.poly) == target) begin
				queue_word(b[7:0], 1'b1);
				return;
			end
		end
	endtask

	function automatic logic [7:0] pick_data();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15) return enc_cfg.flag;
		if (r < 30) return enc_cfg.escape;
		if (r < 35) return 8'h00;
		if (r < 40) return 8'hFF;
		return 8'($urandom());
	endfunction

	// whole frames of random length until about n words are queued
	task automatic queue_frames(input int n);
		int sent;
		int len;
		int r;
		sent = 0;
		while (sent < n) begin
			r = $urandom_range(0, 99);
			if (r < 70) len = $urandom_range(1, 4);
			else if (r < 95) len = $urandom_range(5, 12);
			else len = $urandom_range(13, 30);
			for (int i = 0; i < len; i++) begin
				queue_word(pick_data(), i == len - 1);
			end
			sent += len;
		end
	endtask

	initial begin : stimulus
		cfg_t c;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset values, collisions, crc that needs stuffing
		check_regs();
		queue_word(8'h00, 1'b1);
		queue_word(8'hFF, 1'b1);
		queue_word(8'h7E, 1'b0);
		queue_word(8'h1B, 1'b0);
		queue_word(8'h00, 1'b0);
		queue_word(8'hFF, 1'b1);
		queue_crc_hit(enc_cfg.flag);
		queue_crc_hit(enc_cfg.escape);
		queue_word(8'hA5, 1'b0);
		queue_word(8'h5A, 1'b0);
		queue_word(8'h3C, 1'b1);

		// flag equal to escape, then a write to an unused index
		set_config('{flag: 8'h55, escape: 8'h55, poly: 8'h8C});
		queue_word(8'h55, 1'b1);
		queue_word(8'h55, 1'b0);
		queue_word(8'hAA, 1'b0);
		queue_word(8'h55, 1'b1);
		queue_crc_hit(8'h55);
		wait_drained();
		apb_write(REG_NONE, 8'($urandom()));
		check_regs();

		// random frames under a range of settings
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: c = '{flag: 8'h00, escape: 8'hFF, poly: 8'h00};
				1: c = '{flag: 8'hFF, escape: 8'h00, poly: 8'hFF};
				2: c = '{flag: FLAG_RESET, escape: ESCAPE_RESET, poly: POLY_RESET};
				default: begin
					c.flag   = 8'($urandom());
					c.escape = ($urandom_range(0, 5) == 0) ? c.flag : 8'($urandom());
					c.poly   = 8'($urandom());
				end
			endcase
			set_config(c);
			queue_crc_hit(enc_cfg.flag);
			queue_crc_hit(enc_cfg.escape);
			queue_frames(38);
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

/* files.f */
+incdir+sv
sv/crcbs_pkg.sv
sv/crcbs_front.sv
sv/crcbs_queue.sv
sv/crcbs_back.sv
sv/crc_byte_stuffing_frame_encoder.sv
sv/crcbs_checker.sv
verif/tb_crc_byte_stuffing_frame_encoder.sv
